@@ rtl/mdp_pkg.sv @@
// mdp_pkg: shared types, opcodes and default sizes for the matrix dot product engine
// no dependencies

package mdp_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 4;
    localparam int OP_W   = 2;
    localparam int LEN_W  = 5;

    localparam int OUT_ROWS_DEF  = 16;
    localparam int OUT_COLS_DEF  = 16;
    localparam int INNER_LEN_DEF = 16;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

    localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE    = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic signed [DATA_W-1:0] elem_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] dot_value;
        logic [IDX_W-1:0]         out_row;
        logic [IDX_W-1:0]         out_col;
    } t_out_item;

    typedef struct packed {
        logic clear;
        logic load;
    } t_mac_ctl;

endpackage

@@ rtl/mdp_ram.sv @@
// mdp_ram: generic simple dual port ram, one write port, one registered read port
// no dependencies

module mdp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/mdp_mac.sv @@
// mdp_mac: registered multiply followed by a wrapping 32-bit accumulator
// depends on mdp_pkg

module mdp_mac (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  mdp_pkg::t_mac_ctl        i_ctl,
    input  logic [mdp_pkg::DATA_W-1:0] i_a,
    input  logic [mdp_pkg::DATA_W-1:0] i_b,
    output logic [mdp_pkg::DATA_W-1:0] o_acc,
    output logic                     o_busy
);
    import mdp_pkg::*;

    logic [DATA_W-1:0] r_prod;
    logic [DATA_W-1:0] n_prod;
    logic              r_prod_vld;
    logic [DATA_W-1:0] r_acc;

    // low word of the product is all that survives the wrap
    assign n_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else if (i_ctl.clear) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_prod <= n_prod;
        end
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_prod_vld;

endmodule

@@ rtl/matrix_dot_product_engine.sv @@
// matrix_dot_product_engine: top level, stores both matrices in rams and walks the
// inner dimension one multiply-accumulate per cycle; depends on mdp_pkg, mdp_ram, mdp_mac
//
//  channel   signals                           direction  accept
//  input     i_in_valid / o_in_ready / item    in         valid && ready
//  output    o_out_valid / i_out_ready / item  out        valid && ready
//  config    i_cfg_we / i_cfg_wdata            in         write enable
//
// a load item writes one ram entry when its indices are in range, otherwise it is dropped
// a compute item reads n terms, n = min(active_inner_len, INNER_LEN), through the
// single ram read port per matrix and the multiply and accumulate registers behind it
// an out of range or empty compute goes straight to the finish state with a zero sum
// the next item is accepted while a result waits; a second result waits for the slot
// synchronous active low reset; ram contents are not cleared

module matrix_dot_product_engine #(
    parameter int OUT_ROWS  = mdp_pkg::OUT_ROWS_DEF,
    parameter int OUT_COLS  = mdp_pkg::OUT_COLS_DEF,
    parameter int INNER_LEN = mdp_pkg::INNER_LEN_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [mdp_pkg::LEN_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  mdp_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output mdp_pkg::t_out_item        o_out_item
);
    import mdp_pkg::*;

    localparam int LDEPTH = OUT_ROWS * INNER_LEN;
    localparam int RDEPTH = INNER_LEN * OUT_COLS;
    localparam int LAW = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
    localparam int RAW = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [LEN_W-1:0]  r_inner_len;
    logic [LEN_W-1:0]  r_terms, n_terms;
    logic [LEN_W-1:0]  r_k, n_k;
    logic [IDX_W-1:0]  r_row, r_col;
    logic              r_rd_vld;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              in_acc, out_acc;
    logic              row_ok, col_ok, lrow_ok, lcol_ok, rrow_ok, rcol_ok;
    logic              left_we, right_we, issue, out_load;
    logic [LAW-1:0]    left_waddr, left_raddr;
    logic [RAW-1:0]    right_waddr, right_raddr;
    logic [DATA_W-1:0] left_rdata, right_rdata;
    logic [DATA_W-1:0] mac_acc;
    logic              mac_busy;
    t_mac_ctl          mac_ctl;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = r_out_valid && i_out_ready;

    always_comb begin
        if (32'(r_inner_len) > 32'(INNER_LEN)) begin
            n_terms = LEN_W'(INNER_LEN);
        end else begin
            n_terms = r_inner_len;
        end
    end

    assign row_ok  = 32'(i_in_item.row_index) < 32'(OUT_ROWS);
    assign col_ok  = 32'(i_in_item.col_index) < 32'(OUT_COLS);
    assign lrow_ok = row_ok;
    assign lcol_ok = 32'(i_in_item.col_index) < 32'(INNER_LEN);
    assign rrow_ok = 32'(i_in_item.row_index) < 32'(INNER_LEN);
    assign rcol_ok = col_ok;

    assign left_we  = in_acc && (i_in_item.opcode == OP_LOAD_LEFT) && lrow_ok && lcol_ok;
    assign right_we = in_acc && (i_in_item.opcode == OP_LOAD_RIGHT) && rrow_ok && rcol_ok;

    assign left_waddr  = LAW'(32'(i_in_item.row_index) * INNER_LEN
                              + 32'(i_in_item.col_index));
    assign right_waddr = RAW'(32'(i_in_item.row_index) * OUT_COLS
                              + 32'(i_in_item.col_index));
    assign left_raddr  = LAW'(32'(r_row) * INNER_LEN + 32'(r_k));
    assign right_raddr = RAW'(32'(r_k) * OUT_COLS + 32'(r_col));

    assign issue    = (r_state == S_RUN);
    assign out_load = (r_state == S_FIN) && !r_rd_vld && !mac_busy
                      && (!r_out_valid || i_out_ready);

    assign mac_ctl.clear = in_acc && (i_in_item.opcode == OP_COMPUTE);
    assign mac_ctl.load  = r_rd_vld;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        case (r_state)
            S_IDLE: begin
                n_k = '0;
                if (in_acc && (i_in_item.opcode == OP_COMPUTE)) begin
                    if (row_ok && col_ok && (n_terms != '0)) begin
                        n_state = S_RUN;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_RUN: begin
                n_k = r_k + LEN_W'(1);
                if (n_k == r_terms) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inner_len <= LEN_RESET;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_rd_vld <= issue;
            if (i_cfg_we) begin
                r_inner_len <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_row   <= i_in_item.row_index;
            r_col   <= i_in_item.col_index;
            r_terms <= n_terms;
        end
        if (out_load) begin
            r_out_item.dot_value <= mac_acc;
            r_out_item.out_row   <= r_row;
            r_out_item.out_col   <= r_col;
        end
    end

    mdp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LDEPTH)
    ) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (left_we),
        .i_waddr (left_waddr),
        .i_wdata (i_in_item.elem_value),
        .i_raddr (left_raddr),
        .o_rdata (left_rdata)
    );

    mdp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RDEPTH)
    ) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (right_we),
        .i_waddr (right_waddr),
        .i_wdata (i_in_item.elem_value),
        .i_raddr (right_raddr),
        .o_rdata (right_rdata)
    );

    mdp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (left_rdata),
        .i_b     (right_rdata),
        .o_acc   (mac_acc),
        .o_busy  (mac_busy)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (!left_we && !right_we))
        else $error("ram write while a compute is in flight");

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_k < r_terms))
        else $error("inner index beyond active length");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result loaded outside the finish state");

    a_fin_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |=> !out_load)
        else $error("result taken before the pipeline drained");

endmodule
